// ===== rtl/llca_pkg.sv =====
package llca_pkg;

    localparam int COORD_WIDTH_DEF         = 24;
    localparam int PARAM_FRACTION_BITS_DEF = 16;

    localparam int              THR_WIDTH = 16;
    localparam logic [15:0]     THR_RESET = 16'd1;

    // wide products are split into chunks of this many bits
    localparam int MUL_CHUNK = 26;
    // register stages of llca_mul from operands to product
    localparam int MUL_LAT   = 5;

endpackage

// ===== rtl/llca_delay.sv =====
module llca_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= d;
            for (int k = 1; k < N; k++) begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign q = sr_reg[N-1];

endmodule

// ===== rtl/llca_mul.sv =====
module llca_mul #(
    parameter int AW = 8,
    parameter int BW = 8
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    import llca_pkg::*;

    localparam int PW = AW + BW;
    localparam int CH = MUL_CHUNK;
    localparam int NA = (AW + CH - 1) / CH;
    localparam int NB = (BW + CH - 1) / CH;
    localparam int RW = (NB + 1) * CH;
    localparam int TW = (NA + NB + 1) * CH;

    logic [AW-1:0]      ma_abs;
    logic [BW-1:0]      mb_abs;
    logic [NA*CH-1:0]   ma_reg;
    logic [NB*CH-1:0]   mb_reg;
    logic [3:0]         neg_reg;
    logic [2*CH-1:0]    pp_reg [NA][NB];
    logic [RW-1:0]      row_next [NA];
    logic [RW-1:0]      row_reg [NA];
    logic [TW-1:0]      tot_acc;
    logic [PW-1:0]      tot_next;
    logic [PW-1:0]      tot_reg;
    logic signed [PW-1:0] p_reg;

    // sign and magnitude, the chunks multiply unsigned
    assign ma_abs = a[AW-1] ? AW'(~a + AW'(1)) : AW'(a);
    assign mb_abs = b[BW-1] ? BW'(~b + BW'(1)) : BW'(b);

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (j * CH));
            end
        end
    end

    always_comb begin
        tot_acc = '0;
        for (int i = 0; i < NA; i++) begin
            tot_acc = tot_acc + (TW'(row_reg[i]) << (i * CH));
        end
        tot_next = tot_acc[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg  <= (NA*CH)'(ma_abs);
            mb_reg  <= (NB*CH)'(mb_abs);
            neg_reg <= {neg_reg[2:0], a[AW-1] ^ b[BW-1]};
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= ma_reg[i*CH +: CH] * mb_reg[j*CH +: CH];
                end
                row_reg[i] <= row_next[i];
            end
            tot_reg <= tot_next;
            p_reg   <= neg_reg[3] ? PW'(~tot_reg + PW'(1)) : tot_reg;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/llca_div.sv =====
module llca_div #(
    parameter int NUMW = 8,
    parameter int DENW = 8
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [NUMW-1:0]        num,
    input  logic [DENW-1:0]        den,
    input  logic                   neg,
    output logic signed [NUMW:0]   quo
);

    logic [DENW-1:0] rem_reg [NUMW];
    logic [NUMW-1:0] n_reg   [NUMW];
    logic [NUMW-1:0] q_reg   [NUMW];
    logic [DENW-1:0] d_reg   [NUMW];
    logic [NUMW-1:0] neg_reg;
    logic [NUMW:0]   q_ext;
    logic signed [NUMW:0] quo_reg;

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < NUMW; k++) begin : g_stage
        logic [DENW-1:0] rem_in;
        logic [DENW-1:0] d_in;
        logic [NUMW-1:0] n_in;
        logic [NUMW-1:0] q_in;
        logic            neg_in;
        logic [DENW:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign d_in   = den;
            assign n_in   = num;
            assign q_in   = '0;
            assign neg_in = neg;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign n_in   = n_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        assign trial = {rem_in, n_in[NUMW-1]};
        assign ge    = trial >= {1'b0, d_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? DENW'(trial - {1'b0, d_in}) : DENW'(trial);
                d_reg[k]   <= d_in;
                n_reg[k]   <= n_in << 1;
                q_reg[k]   <= {q_in[NUMW-2:0], ge};
                neg_reg[k] <= neg_in;
            end
        end
    end

    assign q_ext = {1'b0, q_reg[NUMW-1]};

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= neg_reg[NUMW-1] ? (NUMW+1)'(~q_ext + (NUMW+1)'(1)) : q_ext;
        end
    end

    assign quo = quo_reg;

endmodule

// ===== rtl/llca_sqrt.sv =====
module llca_sqrt #(
    parameter int IW = 8
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [IW-1:0]     x,
    output logic [IW/2-1:0]   root
);

    localparam int NS = IW / 2;

    logic [NS+1:0] rem_reg  [NS];
    logic [NS-1:0] root_reg [NS];
    logic [IW-1:0] x_reg    [NS];

    // one result bit per stage, two radicand bits shifted in each time
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [NS-1:0] rem_in;
        logic [NS-1:0] root_in;
        logic [IW-1:0] x_in;
        logic [NS+1:0] t;
        logic [NS+1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = x;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1][NS-1:0];
            assign root_in = root_reg[k-1];
            assign x_in    = x_reg[k-1];
        end

        assign t     = {rem_in, x_in[IW-1:IW-2]};
        assign trial = {root_in, 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? (t - trial) : t;
                root_reg[k] <= {root_in[NS-2:0], ge};
                x_reg[k]    <= x_in << 2;
            end
        end
    end

    assign root = root_reg[NS-1];

endmodule

// ===== rtl/line_line_closest_approach.sv =====
// closest approach of two 3d lines, one line pair per item
//
// s_ channel: twelve signed coordinates, two points per line, valid/ready.
// m_ channel: vertex x/y/z (midpoint of the closest points), the distance
// between the closest points and vertex_valid, valid/ready. vertex_valid is
// 0 and all other fields 0 for a degenerate pair.
// cfg channel: valid/ready write of degenerate_threshold, always ready; write
// it only while no item is in flight.
//
// the restoring divider pipeline, of length NUMW = 4*COORD_WIDTH + 9 +
// PARAM_FRACTION_BITS, and the square root pipeline make up most of the
// path from accept to output.
// throughput: one item per cycle while s_ready is high.
// reset: synchronous, active low; clears all item valid bits and the output
// valid and sets the threshold to 1.
// when the receiver stalls the output register holds its item; items behind
// it keep moving into empty slots, and the whole pipeline, with s_ready, only
// stops when the last stage also holds an item.
module line_line_closest_approach #(
    parameter int COORD_WIDTH         = llca_pkg::COORD_WIDTH_DEF,
    parameter int PARAM_FRACTION_BITS = llca_pkg::PARAM_FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [llca_pkg::THR_WIDTH-1:0]      cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_WIDTH-1:0]       s_line1_a_x,
    input  logic signed [COORD_WIDTH-1:0]       s_line1_a_y,
    input  logic signed [COORD_WIDTH-1:0]       s_line1_a_z,
    input  logic signed [COORD_WIDTH-1:0]       s_line1_b_x,
    input  logic signed [COORD_WIDTH-1:0]       s_line1_b_y,
    input  logic signed [COORD_WIDTH-1:0]       s_line1_b_z,
    input  logic signed [COORD_WIDTH-1:0]       s_line2_a_x,
    input  logic signed [COORD_WIDTH-1:0]       s_line2_a_y,
    input  logic signed [COORD_WIDTH-1:0]       s_line2_a_z,
    input  logic signed [COORD_WIDTH-1:0]       s_line2_b_x,
    input  logic signed [COORD_WIDTH-1:0]       s_line2_b_y,
    input  logic signed [COORD_WIDTH-1:0]       s_line2_b_z,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [COORD_WIDTH-1:0]       m_vertex_x,
    output logic signed [COORD_WIDTH-1:0]       m_vertex_y,
    output logic signed [COORD_WIDTH-1:0]       m_vertex_z,
    output logic [COORD_WIDTH-1:0]              m_closest_distance,
    output logic                                m_vertex_valid
);

    import llca_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int PF   = PARAM_FRACTION_BITS;
    localparam int LM   = MUL_LAT;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW + 2;
    localparam int NW   = 2 * PW + 1;
    localparam int NUMW = NW + PF;
    localparam int SW   = NUMW + 1;
    localparam int SUW  = SW + DW;
    localparam int C1W  = SUW + 1;
    localparam int DDW  = C1W + 1;
    localparam int VW   = DDW - PF - 1;
    localparam int MW   = CW + PF;
    localparam int SQW  = 2 * (MW + 1);
    localparam int NS   = SQW / 2;

    // stage numbers, counted in registers after the input
    localparam int T_DEN = 4 + LM;
    localparam int T_MAG = T_DEN + 1;
    localparam int T_S   = T_MAG + NUMW + 1;
    localparam int T_C   = T_S + LM + 1;
    localparam int T_V   = T_C + 2;
    localparam int T_R   = T_V + LM + 1 + NS;

    logic [THR_WIDTH-1:0] thr_reg;
    logic                 en;
    logic [T_R-1:0]       vld_reg;

    logic signed [CW-1:0] a1 [3];
    logic signed [CW-1:0] b1 [3];
    logic signed [CW-1:0] a2 [3];
    logic signed [CW-1:0] b2 [3];

    logic signed [DW-1:0]   u_reg [3];
    logic signed [DW-1:0]   v_reg [3];
    logic signed [DW-1:0]   w_reg [3];
    logic signed [CW-1:0]   p_reg [3];
    logic signed [CW-1:0]   q_reg [3];
    logic signed [2*DW-1:0] uu_reg [3];
    logic signed [2*DW-1:0] uv_reg [3];
    logic signed [2*DW-1:0] vv_reg [3];
    logic signed [2*DW-1:0] uw_reg [3];
    logic signed [2*DW-1:0] vw_reg [3];
    logic signed [PW-1:0]   a_reg;
    logic signed [PW-1:0]   b_reg;
    logic signed [PW-1:0]   c_reg;
    logic signed [PW-1:0]   d_reg;
    logic signed [PW-1:0]   e_reg;
    logic signed [PW-1:0]   thr_pw;
    logic                   small_reg;
    logic                   small_d;

    logic signed [2*PW-1:0] ac;
    logic signed [2*PW-1:0] bb;
    logic signed [2*PW-1:0] be;
    logic signed [2*PW-1:0] cd;
    logic signed [2*PW-1:0] ae;
    logic signed [2*PW-1:0] bd;
    logic signed [NW-1:0]   ns_raw;
    logic signed [NW-1:0]   nt_raw;
    logic signed [NW-1:0]   den_reg;
    logic signed [NUMW-1:0] ns_reg;
    logic signed [NUMW-1:0] nt_reg;
    logic signed [NW-1:0]   thr_nw;

    logic [NW-1:0]   den_mag_reg;
    logic [NUMW-1:0] ns_mag_reg;
    logic [NUMW-1:0] nt_mag_reg;
    logic            neg_s_reg;
    logic            neg_t_reg;
    logic            deg_reg;
    logic            deg_d;

    logic signed [SW-1:0]  s_q;
    logic signed [SW-1:0]  t_q;
    logic [6*DW-1:0]       uv_pack;
    logic [6*DW-1:0]       uv_d;
    logic [6*CW-1:0]       pq_pack;
    logic [6*CW-1:0]       pq_d;
    logic signed [DW-1:0]  u_d [3];
    logic signed [DW-1:0]  v_d [3];
    logic signed [CW-1:0]  p_d [3];
    logic signed [CW-1:0]  q_d [3];
    logic signed [SUW-1:0] su [3];
    logic signed [SUW-1:0] tv [3];

    logic signed [C1W-1:0] c1_reg [3];
    logic signed [C1W-1:0] c2_reg [3];
    logic signed [DDW-1:0] msum_reg [3];
    logic signed [DDW-1:0] dd_reg [3];

    logic signed [VW-1:0]  m_sh [3];
    logic [CW-1:0]         vx_next [3];
    logic [MW-1:0]         mag_next [3];
    logic [2:0]            over_k;
    logic [CW-1:0]         vx_reg [3];
    logic [MW-1:0]         mag_reg [3];
    logic                  over_reg;

    logic signed [MW:0]    sq_in [3];
    logic signed [SQW-1:0] sq [3];
    logic [SQW-1:0]        sum2_reg;
    logic [NS-1:0]         root;
    logic [3*CW:0]         vs_pack;
    logic [3*CW:0]         vs_d;
    logic [CW:0]           r_sh;
    logic [CW-1:0]         dist_next;

    logic                  m_valid_reg;
    logic [CW-1:0]         vx_out_reg [3];
    logic [CW-1:0]         dist_reg;
    logic                  vvalid_reg;

    // ---------------- configuration

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // ---------------- flow control

    // the pipe only halts when its last stage would overwrite a held output
    assign en      = !(m_valid_reg && !m_ready && vld_reg[T_R-1]);
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[T_R-2:0], s_valid};
        end
    end

    // ---------------- directions, offset, dot products

    assign a1[0] = s_line1_a_x;
    assign a1[1] = s_line1_a_y;
    assign a1[2] = s_line1_a_z;
    assign b1[0] = s_line1_b_x;
    assign b1[1] = s_line1_b_y;
    assign b1[2] = s_line1_b_z;
    assign a2[0] = s_line2_a_x;
    assign a2[1] = s_line2_a_y;
    assign a2[2] = s_line2_a_z;
    assign b2[0] = s_line2_b_x;
    assign b2[1] = s_line2_b_y;
    assign b2[2] = s_line2_b_z;

    assign thr_pw = PW'({1'b0, thr_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                u_reg[k]  <= DW'(b1[k]) - DW'(a1[k]);
                v_reg[k]  <= DW'(b2[k]) - DW'(a2[k]);
                w_reg[k]  <= DW'(a1[k]) - DW'(a2[k]);
                p_reg[k]  <= a1[k];
                q_reg[k]  <= a2[k];
                uu_reg[k] <= u_reg[k] * u_reg[k];
                uv_reg[k] <= u_reg[k] * v_reg[k];
                vv_reg[k] <= v_reg[k] * v_reg[k];
                uw_reg[k] <= u_reg[k] * w_reg[k];
                vw_reg[k] <= v_reg[k] * w_reg[k];
            end
            a_reg <= PW'(uu_reg[0]) + PW'(uu_reg[1]) + PW'(uu_reg[2]);
            b_reg <= PW'(uv_reg[0]) + PW'(uv_reg[1]) + PW'(uv_reg[2]);
            c_reg <= PW'(vv_reg[0]) + PW'(vv_reg[1]) + PW'(vv_reg[2]);
            d_reg <= PW'(uw_reg[0]) + PW'(uw_reg[1]) + PW'(uw_reg[2]);
            e_reg <= PW'(vw_reg[0]) + PW'(vw_reg[1]) + PW'(vw_reg[2]);
            small_reg <= (a_reg < thr_pw) || (c_reg < thr_pw);
        end
    end

    llca_delay #(.W(1), .N(LM)) u_small_dly (
        .aclk(aclk), .en(en), .d(small_reg), .q(small_d)
    );

    // ---------------- determinant and numerators

    llca_mul #(.AW(PW), .BW(PW)) u_mul_ac (.aclk(aclk), .en(en), .a(a_reg), .b(c_reg), .p(ac));
    llca_mul #(.AW(PW), .BW(PW)) u_mul_bb (.aclk(aclk), .en(en), .a(b_reg), .b(b_reg), .p(bb));
    llca_mul #(.AW(PW), .BW(PW)) u_mul_be (.aclk(aclk), .en(en), .a(b_reg), .b(e_reg), .p(be));
    llca_mul #(.AW(PW), .BW(PW)) u_mul_cd (.aclk(aclk), .en(en), .a(c_reg), .b(d_reg), .p(cd));
    llca_mul #(.AW(PW), .BW(PW)) u_mul_ae (.aclk(aclk), .en(en), .a(a_reg), .b(e_reg), .p(ae));
    llca_mul #(.AW(PW), .BW(PW)) u_mul_bd (.aclk(aclk), .en(en), .a(b_reg), .b(d_reg), .p(bd));

    assign ns_raw = NW'(be) - NW'(cd);
    assign nt_raw = NW'(ae) - NW'(bd);
    assign thr_nw = NW'({1'b0, thr_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= NW'(ac) - NW'(bb);
            ns_reg  <= NUMW'(ns_raw) << PF;
            nt_reg  <= NUMW'(nt_raw) << PF;

            den_mag_reg <= den_reg[NW-1] ? NW'(~den_reg + NW'(1)) : NW'(den_reg);
            ns_mag_reg  <= ns_reg[NUMW-1] ? NUMW'(~ns_reg + NUMW'(1)) : NUMW'(ns_reg);
            nt_mag_reg  <= nt_reg[NUMW-1] ? NUMW'(~nt_reg + NUMW'(1)) : NUMW'(nt_reg);
            neg_s_reg   <= ns_reg[NUMW-1] ^ den_reg[NW-1];
            neg_t_reg   <= nt_reg[NUMW-1] ^ den_reg[NW-1];
            // a zero determinant is degenerate even with a zero threshold
            deg_reg     <= small_d || (den_reg == '0) ||
                           ((den_reg < thr_nw) && (den_reg > -thr_nw));
        end
    end

    // ---------------- line parameters

    llca_div #(.NUMW(NUMW), .DENW(NW)) u_div_s (
        .aclk(aclk), .en(en), .num(ns_mag_reg), .den(den_mag_reg),
        .neg(neg_s_reg), .quo(s_q)
    );

    llca_div #(.NUMW(NUMW), .DENW(NW)) u_div_t (
        .aclk(aclk), .en(en), .num(nt_mag_reg), .den(den_mag_reg),
        .neg(neg_t_reg), .quo(t_q)
    );

    assign uv_pack = {u_reg[0], u_reg[1], u_reg[2], v_reg[0], v_reg[1], v_reg[2]};
    assign pq_pack = {p_reg[0], p_reg[1], p_reg[2], q_reg[0], q_reg[1], q_reg[2]};

    llca_delay #(.W(6*DW), .N(T_S-1)) u_uv_dly (
        .aclk(aclk), .en(en), .d(uv_pack), .q(uv_d)
    );

    llca_delay #(.W(6*CW), .N(T_S+LM-1)) u_pq_dly (
        .aclk(aclk), .en(en), .d(pq_pack), .q(pq_d)
    );

    for (genvar k = 0; k < 3; k++) begin : g_axis
        assign u_d[k] = uv_d[(5-k)*DW +: DW];
        assign v_d[k] = uv_d[(2-k)*DW +: DW];
        assign p_d[k] = pq_d[(5-k)*CW +: CW];
        assign q_d[k] = pq_d[(2-k)*CW +: CW];

        llca_mul #(.AW(SW), .BW(DW)) u_mul_su (
            .aclk(aclk), .en(en), .a(s_q), .b(u_d[k]), .p(su[k])
        );
        llca_mul #(.AW(SW), .BW(DW)) u_mul_tv (
            .aclk(aclk), .en(en), .a(t_q), .b(v_d[k]), .p(tv[k])
        );

        assign sq_in[k] = {1'b0, mag_reg[k]};

        llca_mul #(.AW(MW+1), .BW(MW+1)) u_mul_sq (
            .aclk(aclk), .en(en), .a(sq_in[k]), .b(sq_in[k]), .p(sq[k])
        );
    end

    // ---------------- closest points, midpoint, difference

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m_sh[k] = VW'(msum_reg[k] >>> (PF + 1));
            if (&m_sh[k][VW-1:CW-1] || ~|m_sh[k][VW-1:CW-1]) begin
                vx_next[k] = m_sh[k][CW-1:0];
            end else if (m_sh[k][VW-1]) begin
                vx_next[k] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                vx_next[k] = {1'b0, {(CW-1){1'b1}}};
            end
            // over when |dd| reaches 2^MW
            over_k[k] = !(&dd_reg[k][DDW-1:MW] || ~|dd_reg[k][DDW-1:MW]) ||
                        (dd_reg[k][MW] && (dd_reg[k][MW-1:0] == '0));
            mag_next[k] = dd_reg[k][MW] ? MW'(~dd_reg[k][MW:0] + (MW+1)'(1))
                                        : dd_reg[k][MW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                c1_reg[k]   <= (C1W'(p_d[k]) <<< PF) + C1W'(su[k]);
                c2_reg[k]   <= (C1W'(q_d[k]) <<< PF) + C1W'(tv[k]);
                msum_reg[k] <= DDW'(c1_reg[k]) + DDW'(c2_reg[k]) + (DDW'(1) <<< PF);
                dd_reg[k]   <= DDW'(c1_reg[k]) - DDW'(c2_reg[k]);
                vx_reg[k]   <= vx_next[k];
                mag_reg[k]  <= mag_next[k];
            end
            over_reg <= |over_k;
            sum2_reg <= SQW'(sq[0]) + SQW'(sq[1]) + SQW'(sq[2]);
        end
    end

    // ---------------- distance

    llca_sqrt #(.IW(SQW)) u_sqrt (
        .aclk(aclk), .en(en), .x(sum2_reg), .root(root)
    );

    assign vs_pack = {vx_reg[0], vx_reg[1], vx_reg[2], over_reg};

    llca_delay #(.W(3*CW+1), .N(T_R-T_V)) u_vs_dly (
        .aclk(aclk), .en(en), .d(vs_pack), .q(vs_d)
    );

    llca_delay #(.W(1), .N(T_R-T_MAG)) u_deg_dly (
        .aclk(aclk), .en(en), .d(deg_reg), .q(deg_d)
    );

    assign r_sh      = root[NS-1:PF];
    assign dist_next = (vs_d[0] || r_sh[CW]) ? {CW{1'b1}} : r_sh[CW-1:0];

    // ---------------- output register

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= vld_reg[T_R-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            vx_out_reg[0] <= deg_d ? '0 : vs_d[3*CW -: CW];
            vx_out_reg[1] <= deg_d ? '0 : vs_d[2*CW -: CW];
            vx_out_reg[2] <= deg_d ? '0 : vs_d[CW -: CW];
            dist_reg      <= deg_d ? '0 : dist_next;
            vvalid_reg    <= !deg_d;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_vertex_x         = vx_out_reg[0];
    assign m_vertex_y         = vx_out_reg[1];
    assign m_vertex_z         = vx_out_reg[2];
    assign m_closest_distance = dist_reg;
    assign m_vertex_valid     = vvalid_reg;

endmodule

// ===== bench/line_line_closest_approach_test.sv =====
module line_line_closest_approach_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW       = llca_pkg::COORD_WIDTH_DEF;
    localparam int PF       = llca_pkg::PARAM_FRACTION_BITS_DEF;
    localparam int CMAX     = 8388607;
    localparam int CMIN     = -8388608;
    localparam int DRAIN    = 300;
    localparam int LIMIT    = 600000;
    localparam int N_DIR    = 11;
    localparam int N_RAND   = 125;

    typedef logic signed [CW-1:0] coord_t;
    typedef coord_t pair_t [12];
    typedef logic signed [255:0] wide_t;
    typedef struct packed {
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic signed [CW-1:0] vz;
        logic [CW-1:0]        distance;
        logic                 ok;
    } vertex_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [llca_pkg::THR_WIDTH-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_pt [12] = '{default: '0};
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [CW-1:0] m_vertex_x, m_vertex_y, m_vertex_z;
    logic [CW-1:0] m_closest_distance;
    logic m_vertex_valid;

    vertex_t vertex_q [$];
    logic [15:0] cur_thr = llca_pkg::THR_RESET;
    int errors = 0;
    int cycles = 0;
    int s_idle_pct = 0;
    int m_stall_pct = 0;

    line_line_closest_approach dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_line1_a_x        (s_pt[0]),
        .s_line1_a_y        (s_pt[1]),
        .s_line1_a_z        (s_pt[2]),
        .s_line1_b_x        (s_pt[3]),
        .s_line1_b_y        (s_pt[4]),
        .s_line1_b_z        (s_pt[5]),
        .s_line2_a_x        (s_pt[6]),
        .s_line2_a_y        (s_pt[7]),
        .s_line2_a_z        (s_pt[8]),
        .s_line2_b_x        (s_pt[9]),
        .s_line2_b_y        (s_pt[10]),
        .s_line2_b_z        (s_pt[11]),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_vertex_x         (m_vertex_x),
        .m_vertex_y         (m_vertex_y),
        .m_vertex_z         (m_vertex_z),
        .m_closest_distance (m_closest_distance),
        .m_vertex_valid     (m_vertex_valid)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic wide_t isqrt_wide(wide_t val);
        logic [255:0] rem, root, bitv, trial;
        rem = val;
        root = '0;
        bitv = 256'd1 << 254;
        for (int i = 0; i < 128; i++) begin
            trial = root + bitv;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic vertex_t closest_vertex(pair_t p, logic [15:0] thr_reg);
        wide_t p1 [3], q1 [3], u [3], v [3], w [3];
        wide_t a, b, c, d, e, den, thr, s, t, c1, c2, mid, dd, sum2, lo, hi, dlim, r;
        vertex_t res;
        logic over;
        sum2 = '0;
        over = 1'b0;
        lo = CMIN;
        hi = CMAX;
        dlim = wide_t'(1) <<< (CW + PF);
        thr = wide_t'({240'b0, thr_reg});
        for (int k = 0; k < 3; k++) begin
            p1[k] = wide_t'(p[k]);
            q1[k] = wide_t'(p[6 + k]);
            u[k] = wide_t'(p[3 + k]) - p1[k];
            v[k] = wide_t'(p[9 + k]) - q1[k];
            w[k] = p1[k] - q1[k];
        end
        a = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        b = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
        c = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        d = u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
        e = v[0] * w[0] + v[1] * w[1] + v[2] * w[2];
        den = a * c - b * b;
        res = '0;
        if (a < thr || c < thr || (den < 0 ? -den : den) < thr || den == 0)
            return res;
        // truncating division, as the language's signed divide does
        s = ((b * e - c * d) <<< PF) / den;
        t = ((a * e - b * d) <<< PF) / den;
        for (int k = 0; k < 3; k++) begin
            c1 = (p1[k] <<< PF) + s * u[k];
            c2 = (q1[k] <<< PF) + t * v[k];
            mid = (c1 + c2 + (wide_t'(1) <<< PF)) >>> (PF + 1);
            if (mid < lo) mid = lo;
            if (mid > hi) mid = hi;
            dd = c1 - c2;
            if ((dd < 0 ? -dd : dd) >= dlim) over = 1'b1;
            else sum2 = sum2 + dd * dd;
            case (k)
                0: res.vx = mid[CW-1:0];
                1: res.vy = mid[CW-1:0];
                default: res.vz = mid[CW-1:0];
            endcase
        end
        r = isqrt_wide(sum2) >> PF;
        if (over || r > wide_t'((1 << CW) - 1)) res.distance = '1;
        else res.distance = r[CW-1:0];
        res.ok = 1'b1;
        return res;
    endfunction

    function automatic coord_t rand_coord(int span);
        return coord_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int mode, k;
        mode = $urandom_range(9);
        for (int i = 0; i < 12; i++) p[i] = coord_t'($urandom);
        if (mode inside {[4:5]}) begin
            for (int i = 0; i < 12; i++) p[i] = rand_coord(32);
        end else if (mode == 6) begin
            // parallel lines: second direction a multiple of the first
            k = $urandom_range(1, 2) * ($urandom_range(1) ? 1 : -1);
            for (int i = 0; i < 3; i++) begin
                p[i] = rand_coord(1 << 20);
                p[3 + i] = p[i] + rand_coord(1 << 12);
                p[6 + i] = rand_coord(1 << 20);
                p[9 + i] = p[6 + i] + k * (p[3 + i] - p[i]);
            end
        end else if (mode == 7) begin
            for (int i = 0; i < 3; i++) p[9 + i] = p[6 + i];
        end else if (mode >= 8) begin
            // lines passing near a common point
            for (int i = 0; i < 3; i++) begin
                p[i] = rand_coord(1 << 20);
                p[3 + i] = p[i] + rand_coord(1 << 12);
                p[6 + i] = p[i] + rand_coord(64);
                p[9 + i] = p[6 + i] + rand_coord(1 << 12);
            end
        end
        return p;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
        errors++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_pair(pair_t p);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        for (int i = 0; i < 12; i++) s_pt[i] <= p[i];
        do @(posedge aclk); while (!s_ready);
        vertex_q.push_back(closest_vertex(p, cur_thr));
        @(negedge aclk);
    endtask

    task automatic write_threshold(logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cur_thr = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (vertex_q.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= m_stall_pct);
    end

    always @(posedge aclk) begin
        vertex_t want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (vertex_q.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = vertex_q.pop_front();
                if (m_vertex_x !== want.vx) report_mismatch("vertex_x", m_vertex_x, want.vx);
                if (m_vertex_y !== want.vy) report_mismatch("vertex_y", m_vertex_y, want.vy);
                if (m_vertex_z !== want.vz) report_mismatch("vertex_z", m_vertex_z, want.vz);
                if (m_closest_distance !== want.distance)
                    report_mismatch("closest_distance", m_closest_distance, want.distance);
                if (m_vertex_valid !== want.ok)
                    report_mismatch("vertex_valid", m_vertex_valid, want.ok);
            end
        end
    end

    pair_t dir_in [N_DIR] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{5, 5, 5, 5, 5, 5, 0, 0, 0, 16, 0, 0},
        '{0, 0, 0, 16, 0, 0, 0, 16, 0, 32, 16, 0},
        '{0, 0, 0, 16, 0, 0, 0, 16, 0, 0, 32, 0},
        '{0, 0, 0, 16, 0, 0, 0, 0, 32, 0, 16, 32},
        '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX},
        '{0, 0, CMIN, 16, 0, CMIN, 0, 0, CMAX, 0, 16, CMAX},
        '{-1, -1, -1, CMIN, 0, -1, CMAX, -1, 0, -1, CMIN, CMAX},
        '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 1},
        '{0, 0, 0, 1000, 0, 0, 0, 1000000, 0, 1000, 999999, 0},
        '{CMIN, CMIN, 0, CMAX, CMIN + 1, 0, CMIN, CMAX, 5, CMAX, CMAX - 1, 0}
    };
    // expected values that follow directly from the geometry
    bit dir_known [N_DIR] = '{1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0};
    vertex_t dir_exp [N_DIR] = '{
        vertex_t'(0), vertex_t'(0), vertex_t'(0),
        '{vx: 0, vy: 0, vz: 0, distance: 0, ok: 1},
        '{vx: 0, vy: 0, vz: 16, distance: 32, ok: 1},
        vertex_t'(0), vertex_t'(0), vertex_t'(0), vertex_t'(0), vertex_t'(0), vertex_t'(0)
    };

    int idle_tab [4] = '{0, 81, 0, 37};
    int stall_tab [4] = '{0, 0, 81, 37};

    initial begin
        logic [15:0] thr_tab [4];
        thr_tab = '{16'd1, 16'd0, 16'hFFFF, 16'($urandom)};
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int i = 0; i < N_DIR; i++) begin
            send_pair(dir_in[i]);
            if (dir_known[i] && vertex_q[$] !== dir_exp[i])
                report_mismatch("directed row prediction", i, -1);
        end
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_threshold(thr_tab[ph]);
            s_idle_pct = idle_tab[ph];
            m_stall_pct = stall_tab[ph];
            for (int n = 0; n < N_RAND; n++) send_pair(rand_pair());
            // parallel lines under a zero threshold must still come out degenerate
            if (ph == 1) send_pair(dir_in[2]);
        end
        drain();
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
